### sv/lsp_pkg.sv
// ----------------------------------------------------------------------------
// LIFO stack package
// Shared types and constants for the stack cells, the controller and the top.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int DEPTH_DEF      = 256;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int OP_W     = 2;
   localparam int WORD_W   = 32;
   localparam int PEEK_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 9;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_PEEK = 1'b1
   } state_type;

   // Per-cycle commands broadcast to every cell of the chain.
   typedef struct packed {
      logic push;   // shift stored words one cell deeper
      logic pop;    // shift stored words one cell toward the top
      logic load;   // copy stored words into the read taps
      logic shift;  // move the read taps one cell toward the top
   } cell_ctl_type;

endpackage

### sv/lifo_stack_with_peek.sv
// ----------------------------------------------------------------------------
// LIFO stack with peek
// Last-in first-out word stack built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge with start high and busy low. Every
// transaction produces exactly one response, shown for a single cycle with
// rsp_valid high; the receiver must take it then, as there is no way to stall
// the block. Push, pop and clear respond in the cycle after acceptance, and
// busy stays low, so one of them can be accepted in every cycle. A successful
// peek at distance d holds busy high while the read taps of the cell chain,
// loaded at acceptance, are moved toward the top one cell per cycle until
// entry d reaches the top tap; then it responds. A peek that fails (empty stack
// or distance at or beyond the count) responds in the cycle after acceptance.
// The capacity register may only be written while no transaction is pending;
// values above DEPTH behave as DEPTH, and zero makes every push report full.
// Failed operations leave the stack and the count untouched.
// ----------------------------------------------------------------------------
module lifo_stack_with_peek #(
   parameter int DEPTH      = lsp_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = lsp_pkg::DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            start,
   output logic                            busy,
   input  logic [lsp_pkg::OP_W-1:0]        req_op,
   input  logic [lsp_pkg::WORD_W-1:0]      req_push_value,
   input  logic [lsp_pkg::PEEK_W-1:0]      req_peek_depth,
   // Response channel.
   output logic                            rsp_valid,
   output logic [lsp_pkg::STATUS_W-1:0]    rsp_status,
   output logic [lsp_pkg::WORD_W-1:0]      rsp_read_value,
   output logic [lsp_pkg::COUNT_W-1:0]     rsp_entry_count,
   // Capacity register.
   input  logic                            csr_wr_en,
   input  logic [lsp_pkg::CAP_W-1:0]       csr_wr_data
);

   logic [lsp_pkg::CAP_W-1:0] capacity_ff, capacity_in;

   // Cell 0 always holds the top of the stack; deeper entries sit further down.
   logic [DATA_WIDTH-1:0]     cell_data [DEPTH];
   logic [DATA_WIDTH-1:0]     tap_data  [DEPTH];
   logic [DATA_WIDTH-1:0]     push_word;
   lsp_pkg::cell_ctl_type     cell_ctl;

   assign capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lsp_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Pushed words keep only the bits the store is built for.
   assign push_word = DATA_WIDTH'(64'(req_push_value));

   // Controller: decides which way the chain moves and forms the response.
   lsp_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_peek_depth  (req_peek_depth),
      .capacity        (capacity_ff),
      .top_data        (cell_data[0]),
      .tap_data        (tap_data[0]),
      .cell_ctl        (cell_ctl),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count)
   );

   // The chain: a push moves every word one cell down with the new word entering
   // at the top; a pop moves them up. Words that drop off the bottom were never
   // in use, since a push into a full chain is refused.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] above_data;
      logic [DATA_WIDTH-1:0] below_data;
      logic [DATA_WIDTH-1:0] below_tap;

      if (i == 0) begin : g_top
         assign above_data = push_word;
      end else begin : g_inner
         assign above_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_bottom
         assign below_data = '0;
         assign below_tap  = '0;
      end else begin : g_upper
         assign below_data = cell_data[i+1];
         assign below_tap  = tap_data[i+1];
      end

      lsp_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .above_data (above_data),
         .below_data (below_data),
         .below_tap  (below_tap),
         .cell_data  (cell_data[i]),
         .tap_data   (tap_data[i])
      );
   end

`ifndef SYNTHESIS
   // Every operation except peek answers in the very next cycle.
   a_fast_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op != lsp_pkg::OP_PEEK)) |=> rsp_valid)
      else $error("push, pop or clear did not respond in the next cycle");

   // A failed operation never returns data.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != lsp_pkg::STAT_OK)) |-> (rsp_read_value == '0))
      else $error("failed operation returned a nonzero word");

   // The count reported never exceeds the built depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_entry_count) <= 32'(DEPTH)))
      else $error("entry count beyond stack depth");

   // A clear always answers with an empty stack.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == lsp_pkg::OP_CLEAR)) |=>
         (rsp_entry_count == '0 && rsp_status == lsp_pkg::STAT_OK))
      else $error("clear did not empty the stack");
`endif

endmodule

### sv/lsp_cell.sv
// ----------------------------------------------------------------------------
// LIFO stack cell
// One stack entry plus one read tap; both move to a neighbor on command.
// ----------------------------------------------------------------------------
module lsp_cell #(
   parameter int DATA_WIDTH = lsp_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  lsp_pkg::cell_ctl_type   ctl,
   input  logic [DATA_WIDTH-1:0]   above_data,
   input  logic [DATA_WIDTH-1:0]   below_data,
   input  logic [DATA_WIDTH-1:0]   below_tap,
   output logic [DATA_WIDTH-1:0]   cell_data,
   output logic [DATA_WIDTH-1:0]   tap_data
);

   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [DATA_WIDTH-1:0] tap_ff, tap_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.push) begin
         word_in = above_data;
      end else if (ctl.pop) begin
         word_in = below_data;
      end
      tap_in = tap_ff;
      if (ctl.load) begin
         tap_in = word_ff;
      end else if (ctl.shift) begin
         tap_in = below_tap;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      tap_ff  <= tap_in;
   end

   assign cell_data = word_ff;
   assign tap_data  = tap_ff;

endmodule

### sv/lsp_ctrl.sv
// ----------------------------------------------------------------------------
// LIFO stack controller
// Entry count, operation checks, peek sequencing and the response register.
// ----------------------------------------------------------------------------
module lsp_ctrl #(
   parameter int DEPTH      = lsp_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = lsp_pkg::DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [lsp_pkg::OP_W-1:0]        req_op,
   input  logic [lsp_pkg::PEEK_W-1:0]      req_peek_depth,
   input  logic [lsp_pkg::CAP_W-1:0]       capacity,
   input  logic [DATA_WIDTH-1:0]           top_data,
   input  logic [DATA_WIDTH-1:0]           tap_data,
   output lsp_pkg::cell_ctl_type           cell_ctl,
   output logic                            rsp_valid,
   output logic [lsp_pkg::STATUS_W-1:0]    rsp_status,
   output logic [lsp_pkg::WORD_W-1:0]      rsp_read_value,
   output logic [lsp_pkg::COUNT_W-1:0]     rsp_entry_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   lsp_pkg::state_type             state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [lsp_pkg::PEEK_W-1:0]     remain_ff, remain_in;
   logic                           valid_ff, valid_in;
   lsp_pkg::status_type            status_ff, status_in;
   logic [lsp_pkg::WORD_W-1:0]     value_ff, value_in;

   lsp_pkg::op_type                op;
   logic [31:0]                    count_w, cap_w, eff_cap_w, dist_w;

   assign op        = lsp_pkg::op_type'(req_op);
   assign count_w   = 32'(count_ff);
   assign cap_w     = 32'(capacity);
   assign eff_cap_w = (cap_w > 32'(DEPTH)) ? 32'(DEPTH) : cap_w;
   assign dist_w    = 32'(req_peek_depth);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      valid_in  = 1'b0;
      status_in = status_ff;
      value_in  = value_ff;
      cell_ctl  = '0;
      busy      = 1'b0;

      unique case (state_ff)
         lsp_pkg::S_IDLE: begin
            if (start) begin
               status_in = lsp_pkg::STAT_OK;
               value_in  = '0;
               valid_in  = 1'b1;
               unique case (op)
                  lsp_pkg::OP_PUSH: begin
                     if (count_w >= eff_cap_w) begin
                        status_in = lsp_pkg::STAT_FULL;
                     end else begin
                        cell_ctl.push = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  lsp_pkg::OP_POP: begin
                     if (count_w == 32'd0) begin
                        status_in = lsp_pkg::STAT_EMPTY;
                     end else begin
                        cell_ctl.pop = 1'b1;
                        count_in     = count_ff - CNT_W'(1);
                        value_in     = lsp_pkg::WORD_W'(64'(top_data));
                     end
                  end
                  lsp_pkg::OP_PEEK: begin
                     if (count_w == 32'd0) begin
                        status_in = lsp_pkg::STAT_EMPTY;
                     end else if (dist_w >= count_w) begin
                        status_in = lsp_pkg::STAT_RANGE;
                     end else begin
                        // Result comes from the tap chain once it has moved far enough.
                        valid_in      = 1'b0;
                        cell_ctl.load = 1'b1;
                        remain_in     = req_peek_depth;
                        state_in      = lsp_pkg::S_PEEK;
                     end
                  end
                  lsp_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         lsp_pkg::S_PEEK: begin
            busy = 1'b1;
            if (remain_ff == '0) begin
               valid_in  = 1'b1;
               status_in = lsp_pkg::STAT_OK;
               value_in  = lsp_pkg::WORD_W'(64'(tap_data));
               state_in  = lsp_pkg::S_IDLE;
            end else begin
               cell_ctl.shift = 1'b1;
               remain_in      = remain_ff - lsp_pkg::PEEK_W'(1);
            end
         end
         default: begin
            state_in = lsp_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsp_pkg::S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      remain_ff <= remain_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_read_value  = value_ff;
   assign rsp_entry_count = lsp_pkg::COUNT_W'(32'(count_ff));

endmodule

### tb/lifo_stack_with_peek_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIFO stack with peek testbench
// Drives push, pop, peek and clear transactions into the stack. It keeps its
// own copy of the stack contents and count and checks every response field
// against that copy. The capacity register is changed between phases.
// ----------------------------------------------------------------------------
module lifo_stack_with_peek_tb;

   import lsp_pkg::*;

   localparam int STACK_DEPTH  = DEPTH_DEF;
   localparam int IDX_W        = $clog2(STACK_DEPTH);
   // Longest correct stretch without any transaction is a peek at the deepest
   // entry plus a sender gap, so this limit leaves a wide margin.
   localparam int STALL_LIMIT  = 3000;
   localparam int SETTLE_TIME  = 300;

   typedef struct {
      op_type                op;
      logic [WORD_W-1:0]     push_value;
      logic [PEEK_W-1:0]     peek_depth;
   } stack_cmd_type;

   typedef struct {
      status_type            status;
      logic [WORD_W-1:0]     read_value;
      logic [COUNT_W-1:0]    entry_count;
   } stack_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_op = OP_PUSH;
   logic [WORD_W-1:0]     req_push_value = '0;
   logic [PEEK_W-1:0]     req_peek_depth = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [WORD_W-1:0]     rsp_read_value;
   logic [COUNT_W-1:0]    rsp_entry_count;
   logic                  csr_wr_en = 1'b0;
   logic [CAP_W-1:0]      csr_wr_data = '0;

   // Commands waiting to be offered, and responses the stack still owes us.
   stack_cmd_type         cmd_q[$];
   stack_rsp_type         rsp_due_q[$];
   stack_cmd_type         offered_cmd;

   // Our own copy of the stack state and the capacity register.
   logic [WORD_W-1:0]     mirror_words [STACK_DEPTH];
   int                    mirror_count = 0;
   logic [CAP_W-1:0]      mirror_cap = CAP_RESET;

   int                    idle_pct = 0;
   int                    error_count = 0;
   int                    quiet_cycles = 0;

   lifo_stack_with_peek dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_push_value  (req_push_value),
      .req_peek_depth  (req_peek_depth),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one command to the mirrored stack and returns the response the
   // design must give for it. Failed operations leave the mirror untouched.
   function automatic stack_rsp_type apply_stack_op(stack_cmd_type cmd);
      stack_rsp_type rsp;
      int            limit;
      int            pos;
      limit = (mirror_cap > STACK_DEPTH) ? STACK_DEPTH : int'(mirror_cap);
      rsp.status     = STAT_OK;
      rsp.read_value = '0;
      case (cmd.op)
         OP_PUSH: begin
            if (mirror_count >= limit) begin
               rsp.status = STAT_FULL;
            end else begin
               mirror_words[mirror_count[IDX_W-1:0]] = cmd.push_value;
               mirror_count++;
            end
         end
         OP_POP: begin
            if (mirror_count == 0) begin
               rsp.status = STAT_EMPTY;
            end else begin
               mirror_count--;
               rsp.read_value = mirror_words[mirror_count[IDX_W-1:0]];
            end
         end
         OP_PEEK: begin
            if (mirror_count == 0) begin
               rsp.status = STAT_EMPTY;
            end else if (int'(cmd.peek_depth) >= mirror_count) begin
               rsp.status = STAT_RANGE;
            end else begin
               pos = mirror_count - 1 - int'(cmd.peek_depth);
               rsp.read_value = mirror_words[pos[IDX_W-1:0]];
            end
         end
         default: begin
            mirror_count = 0;
         end
      endcase
      rsp.entry_count = mirror_count[COUNT_W-1:0];
      return rsp;
   endfunction

   // Draws a command with the given percentages of push, pop and peek; the
   // remainder are clears. Peek distances lean toward the top of the stack.
   function automatic stack_cmd_type random_cmd(int push_pct, int pop_pct, int peek_pct);
      stack_cmd_type cmd;
      int            roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
         cmd.op = OP_PUSH;
      else if (roll < push_pct + pop_pct)
         cmd.op = OP_POP;
      else if (roll < push_pct + pop_pct + peek_pct)
         cmd.op = OP_PEEK;
      else
         cmd.op = OP_CLEAR;
      cmd.push_value = $urandom;
      if ($urandom_range(0, 1) == 0)
         cmd.peek_depth = PEEK_W'($urandom_range(0, 7));
      else
         cmd.peek_depth = PEEK_W'($urandom_range(0, 255));
      return cmd;
   endfunction

   // Driver. A transaction is taken at an edge where start is high and busy is
   // low; the expected response is worked out at that same edge. A command that
   // has been offered stays on the ports until it is taken.
   always @(posedge clock) begin : driver
      logic ready_for_next;
      if (reset) begin
         start <= 1'b0;
      end else begin
         ready_for_next = !start;
         if (start && !busy) begin
            rsp_due_q.push_back(apply_stack_op(offered_cmd));
            ready_for_next = 1'b1;
         end
         if (ready_for_next) begin
            if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               offered_cmd    = cmd_q.pop_front();
               start          <= 1'b1;
               req_op         <= offered_cmd.op;
               req_push_value <= offered_cmd.push_value;
               req_peek_depth <= offered_cmd.peek_depth;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. The design cannot be stalled, so every cycle with rsp_valid high
   // carries a response that is matched against the oldest one owed.
   always @(posedge clock) begin : monitor
      stack_rsp_type due;
      if (!reset && rsp_valid === 1'b1) begin
         if (rsp_due_q.size() == 0) begin
            $error("response with no transaction outstanding: status %0d value %08h count %0d",
                   rsp_status, rsp_read_value, rsp_entry_count);
            error_count++;
         end else begin
            due = rsp_due_q.pop_front();
            if (rsp_status !== due.status) begin
               $error("rsp_status mismatch: expected %0d, actual %0d", due.status, rsp_status);
               error_count++;
            end
            if (rsp_read_value !== due.read_value) begin
               $error("rsp_read_value mismatch: expected %08h, actual %08h",
                      due.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_entry_count !== due.entry_count) begin
               $error("rsp_entry_count mismatch: expected %0d, actual %0d",
                      due.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog: any accepted transaction or response restarts the count, so
   // only a real hang can reach the limit.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The capacity register is only touched while the stack is idle, so the
   // mirror can follow it directly.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      mirror_cap  = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Waits at falling edges, away from the driver and monitor, until every
   // command has been taken and every response has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_q.size() != 0 || start || rsp_due_q.size() != 0);
   endtask

   task automatic queue_random(int n, int push_pct, int pop_pct, int peek_pct);
      repeat (n) cmd_q.push_back(random_cmd(push_pct, pop_pct, peek_pct));
   endtask

   function automatic stack_cmd_type make_cmd(op_type op, logic [WORD_W-1:0] value,
                                              logic [PEEK_W-1:0] distance);
      stack_cmd_type cmd;
      cmd.op         = op;
      cmd.push_value = value;
      cmd.peek_depth = distance;
      return cmd;
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed phase at full capacity: pop and peek on an empty stack, the
      // extreme words, peeks at the top, the bottom and just beyond it, the
      // widest distance, and a clear followed by reads of the empty stack.
      // It ends with six entries held so that the next, smaller capacity
      // starts out below the count.
      write_capacity(CAP_W'(STACK_DEPTH));
      idle_pct = 0;
      cmd_q.push_back(make_cmd(OP_POP,   '0,            '0));
      cmd_q.push_back(make_cmd(OP_PEEK,  '0,            '0));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'h0000_0000, '0));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'hFFFF_FFFF, 8'hFF));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'hA5A5_5A5A, '0));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'h5A5A_A5A5, '0));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'h0000_0001, '0));
      cmd_q.push_back(make_cmd(OP_PEEK,  '0,            8'd0));
      cmd_q.push_back(make_cmd(OP_PEEK,  '0,            8'd4));
      cmd_q.push_back(make_cmd(OP_PEEK,  '0,            8'd5));
      cmd_q.push_back(make_cmd(OP_PEEK,  32'hFFFF_FFFF, 8'd255));
      cmd_q.push_back(make_cmd(OP_POP,   '0,            '0));
      cmd_q.push_back(make_cmd(OP_POP,   '0,            '0));
      cmd_q.push_back(make_cmd(OP_CLEAR, 32'hFFFF_FFFF, 8'hFF));
      cmd_q.push_back(make_cmd(OP_POP,   '0,            '0));
      cmd_q.push_back(make_cmd(OP_PEEK,  '0,            '0));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'hFFFF_FFFF, '0));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'h8000_0001, '0));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'h7FFF_FFFE, '0));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'h1234_5678, '0));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'hDEAD_BEEF, '0));
      cmd_q.push_back(make_cmd(OP_PUSH,  32'h0000_FFFF, '0));
      wait_drained();

      // Capacity lowered below the count: pushes must fail until enough pops
      // bring the count under four. The sender idles about half the time.
      write_capacity(9'd4);
      idle_pct = 51;
      queue_random(40, 50, 25, 20);
      wait_drained();

      // Zero capacity: every push reports full, reads still work.
      write_capacity(9'd0);
      idle_pct = 0;
      queue_random(20, 50, 25, 20);
      wait_drained();

      // All capacity bits set, which saturates at the built depth. A push-heavy
      // stream fills the stack to the top and keeps pushing against the full
      // condition, with peeks that reach down to the deepest entry.
      write_capacity(9'h1FF);
      idle_pct = 51;
      queue_random(320, 90, 3, 7);
      wait_drained();

      // Capacity of one with a full stack: pushes fail, pops and clears bring
      // the count down, and the stack then holds at most one entry.
      write_capacity(9'd1);
      idle_pct = 7;
      queue_random(30, 40, 30, 20);
      wait_drained();

      repeat (SETTLE_TIME) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### lifo_stack_with_peek.f
sv/lsp_pkg.sv
sv/lsp_cell.sv
sv/lsp_ctrl.sv
sv/lifo_stack_with_peek.sv
tb/lifo_stack_with_peek_tb.sv
